// ===== hdl/tgarle_pkg.sv =====
`timescale 1ns / 1ps
package tgarle_pkg;

   // parser phases
   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_ID     = 3'd1,
      PH_PACKET = 3'd2,
      PH_PIXEL  = 3'd3,
      PH_DONE   = 3'd4
   } phase_type;

   // result kinds
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_RUN    = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_BAD_TYPE  = 2'd1;
   localparam logic [1:0] STAT_BAD_DEPTH = 2'd2;
   localparam logic [1:0] STAT_TRUNC     = 2'd3;

   // header byte offsets
   localparam logic [4:0] HDR_ID_LEN    = 5'd0;
   localparam logic [4:0] HDR_TYPE      = 5'd2;
   localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
   localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
   localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
   localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
   localparam logic [4:0] HDR_BPP       = 5'd16;
   localparam logic [4:0] HDR_LAST      = 5'd17;

   // image types and pixel sizes
   localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
   localparam logic [7:0] TYPE_RLE       = 8'd10;
   localparam logic [7:0] BPP_24         = 8'd24;
   localparam logic [7:0] BPP_32         = 8'd32;

   localparam logic [7:0] PKT_RUN_MASK   = 8'h80;
   localparam logic [7:0] PKT_COUNT_MASK = 8'h7f;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [7:0]  repeat_count;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [2:0]  channels;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

endpackage

// ===== hdl/tgarle_core.sv =====
`timescale 1ns / 1ps
module tgarle_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_valid,
   input  logic [7:0]          step_byte,
   input  logic                step_eof,
   output logic                out_valid,
   output tgarle_pkg::rsp_type out_item
);
   import tgarle_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [4:0]  header_index_ff, header_index_in;
   logic [7:0]  id_length_ff, id_length_in;
   logic [7:0]  image_kind_ff, image_kind_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [7:0]  pixel_bits_ff, pixel_bits_in;
   logic [31:0] pixels_left_ff, pixels_left_in;
   logic [7:0]  packet_left_ff, packet_left_in;
   logic        packet_is_run_ff, packet_is_run_in;
   logic [1:0]  byte_in_pixel_ff, byte_in_pixel_in;
   logic [23:0] pixel_bytes_ff, pixel_bytes_in;

   logic [2:0]  depth;
   logic [2:0]  bip_next;
   logic [31:0] col;
   logic [7:0]  count_cand;
   logic [7:0]  count;
   logic [31:0] pixels_after;
   logic [7:0]  packet_after;
   logic        is_rle;
   logic [31:0] area;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HEADER;
         header_index_ff  <= '0;
         id_length_ff     <= '0;
         image_kind_ff    <= '0;
         width_ff         <= '0;
         height_ff        <= '0;
         pixel_bits_ff    <= '0;
         pixels_left_ff   <= '0;
         packet_left_ff   <= '0;
         packet_is_run_ff <= 1'b0;
         byte_in_pixel_ff <= '0;
         pixel_bytes_ff   <= '0;
      end else if (step_valid) begin
         phase_ff         <= phase_in;
         header_index_ff  <= header_index_in;
         id_length_ff     <= id_length_in;
         image_kind_ff    <= image_kind_in;
         width_ff         <= width_in;
         height_ff        <= height_in;
         pixel_bits_ff    <= pixel_bits_in;
         pixels_left_ff   <= pixels_left_in;
         packet_left_ff   <= packet_left_in;
         packet_is_run_ff <= packet_is_run_in;
         byte_in_pixel_ff <= byte_in_pixel_in;
         pixel_bytes_ff   <= pixel_bytes_in;
      end
   end

   always_comb begin
      depth    = (pixel_bits_ff == BPP_32) ? 3'd4 : 3'd3;
      bip_next = {1'b0, byte_in_pixel_ff} + 3'd1;
      is_rle   = (image_kind_ff == TYPE_RLE);
      area     = {16'h0000, width_ff} * {16'h0000, height_ff};

      // final byte of a pixel lands above the bytes gathered so far
      col = {8'h00, pixel_bytes_ff};
      case (byte_in_pixel_ff)
         2'd0:    col[7:0]   = col[7:0]   | step_byte;
         2'd1:    col[15:8]  = col[15:8]  | step_byte;
         2'd2:    col[23:16] = col[23:16] | step_byte;
         default: col[31:24] = col[31:24] | step_byte;
      endcase

      count_cand   = (is_rle && packet_is_run_ff) ? packet_left_ff : 8'd1;
      count        = (pixels_left_ff < {24'h000000, count_cand}) ?
                     pixels_left_ff[7:0] : count_cand;
      pixels_after = pixels_left_ff - {24'h000000, count};
      packet_after = packet_is_run_ff ? 8'd0 : packet_left_ff - 8'd1;

      phase_in         = phase_ff;
      header_index_in  = header_index_ff;
      id_length_in     = id_length_ff;
      image_kind_in    = image_kind_ff;
      width_in         = width_ff;
      height_in        = height_ff;
      pixel_bits_in    = pixel_bits_ff;
      pixels_left_in   = pixels_left_ff;
      packet_left_in   = packet_left_ff;
      packet_is_run_in = packet_is_run_ff;
      byte_in_pixel_in = byte_in_pixel_ff;
      pixel_bytes_in   = pixel_bytes_ff;

      out_valid = 1'b0;
      out_item  = '0;

      case (phase_ff)
         PH_HEADER: begin
            case (header_index_ff)
               HDR_ID_LEN:    id_length_in  = step_byte;
               HDR_TYPE:      image_kind_in = step_byte;
               HDR_WIDTH_LO:  width_in      = {width_ff[15:8], step_byte};
               HDR_WIDTH_HI:  width_in      = {step_byte, width_ff[7:0]};
               HDR_HEIGHT_LO: height_in     = {height_ff[15:8], step_byte};
               HDR_HEIGHT_HI: height_in     = {step_byte, height_ff[7:0]};
               HDR_BPP:       pixel_bits_in = step_byte;
               default: ;
            endcase
            if (header_index_ff != HDR_LAST) begin
               header_index_in = header_index_ff + 5'd1;
            end else begin
               header_index_in = '0;
               out_valid       = 1'b1;
               if (image_kind_ff != TYPE_TRUECOLOR && !is_rle) begin
                  out_item.kind   = KIND_ERROR;
                  out_item.status = STAT_BAD_TYPE;
                  out_item.last   = 1'b1;
                  phase_in        = PH_DONE;
               end else if (pixel_bits_ff != BPP_24 && pixel_bits_ff != BPP_32) begin
                  out_item.kind   = KIND_ERROR;
                  out_item.status = STAT_BAD_DEPTH;
                  out_item.last   = 1'b1;
                  phase_in        = PH_DONE;
               end else begin
                  pixels_left_in        = area;
                  out_item.kind         = KIND_HEADER;
                  out_item.image_width  = width_ff;
                  out_item.image_height = height_ff;
                  out_item.channels     = depth;
                  if (width_ff == 16'h0000 || height_ff == 16'h0000) begin
                     out_item.last = 1'b1;
                     phase_in      = PH_DONE;
                  end else if (id_length_ff != 8'h00) begin
                     phase_in = PH_ID;
                  end else begin
                     byte_in_pixel_in = '0;
                     pixel_bytes_in   = '0;
                     packet_left_in   = '0;
                     packet_is_run_in = 1'b0;
                     phase_in         = is_rle ? PH_PACKET : PH_PIXEL;
                  end
               end
            end
         end
         PH_ID: begin
            id_length_in = id_length_ff - 8'd1;
            if (id_length_ff == 8'd1) begin
               byte_in_pixel_in = '0;
               pixel_bytes_in   = '0;
               packet_left_in   = '0;
               packet_is_run_in = 1'b0;
               phase_in         = is_rle ? PH_PACKET : PH_PIXEL;
            end
         end
         PH_PACKET: begin
            packet_is_run_in = (step_byte & PKT_RUN_MASK) != 8'h00;
            packet_left_in   = (step_byte & PKT_COUNT_MASK) + 8'd1;
            byte_in_pixel_in = '0;
            pixel_bytes_in   = '0;
            phase_in         = PH_PIXEL;
         end
         PH_PIXEL: begin
            if (bip_next < depth) begin
               pixel_bytes_in   = col[23:0];
               byte_in_pixel_in = bip_next[1:0];
            end else begin
               out_valid             = 1'b1;
               out_item.kind         = KIND_RUN;
               out_item.red          = col[23:16];
               out_item.green        = col[15:8];
               out_item.blue         = col[7:0];
               out_item.alpha        = (depth == 3'd4) ? col[31:24] : 8'h00;
               out_item.repeat_count = count;
               out_item.channels     = depth;
               pixels_left_in        = pixels_after;
               byte_in_pixel_in      = '0;
               pixel_bytes_in        = '0;
               if (pixels_after == 32'h0000_0000) begin
                  out_item.last = 1'b1;
                  phase_in      = PH_DONE;
               end else if (is_rle) begin
                  packet_left_in = packet_after;
                  if (packet_after == 8'h00) begin
                     phase_in = PH_PACKET;
                  end
               end
            end
         end
         default: phase_in = PH_DONE;
      endcase

      // end of file before the image is complete overrides any result
      if (step_eof) begin
         if (phase_in != PH_DONE) begin
            out_valid       = 1'b1;
            out_item        = '0;
            out_item.kind   = KIND_ERROR;
            out_item.status = STAT_TRUNC;
            out_item.last   = 1'b1;
         end
         phase_in        = PH_HEADER;
         header_index_in = '0;
      end
   end

   a_eof_restarts: assert property (@(posedge clock) disable iff (reset)
      (step_valid && step_eof) |=> (phase_ff == PH_HEADER && header_index_ff == 5'd0))
      else $error("parser did not restart after end of file");

   a_pixel_has_work: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PIXEL || phase_ff == PH_PACKET) |-> (pixels_left_ff != 32'h0))
      else $error("pixel phase with no pixels left");

   a_run_count: assert property (@(posedge clock) disable iff (reset)
      (step_valid && out_valid && out_item.kind == KIND_RUN) |->
      (out_item.repeat_count != 8'h00 && out_item.repeat_count <= 8'd128))
      else $error("run record with bad repeat count");

endmodule

// ===== hdl/tga_rle_image_decoder.sv =====
`timescale 1ns / 1ps
// channel  | dir | tdata                                          | tuser | tlast
// req_     | in  | data_byte                                      | -     | end_of_file
// rsp_     | out | red green blue alpha repeat_count image_width  | kind  | last
//          |     | image_height channels status (low bit first)   |       |
//
// One byte per cycle sustained while the result buffer has room. An accepted byte
// waits in the input register until the result buffer has room; the parser then
// updates its state and writes any result into a two-entry result buffer.
// req_tready drops only while the input register is full and the result buffer
// holds two items; both depend on registers alone.
// Synchronous reset clears the parser and both buffers; no clearing pass.
module tga_rle_image_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // red, green, blue, alpha, repeat_count, image_width,
                                    // image_height, channels, status, zero pad
   output logic [1:0]  rsp_tuser,   // [1:0] result_kind
   output logic        rsp_tlast
);
   import tgarle_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eof_ff;
   logic       advance;
   logic       req_take;

   logic       res_valid;
   rsp_type    res_item;

   logic [1:0] count_ff, count_in;
   rsp_type    head_ff, head_in;
   rsp_type    tail_ff, tail_in;
   logic       push;
   logic       pop;

   assign advance    = in_valid_ff && (count_ff != 2'd2);
   assign req_tready = !in_valid_ff || (count_ff != 2'd2);
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_eof_ff  <= req_tlast;
      end
   end

   tgarle_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_valid (advance),
      .step_byte  (in_byte_ff),
      .step_eof   (in_eof_ff),
      .out_valid  (res_valid),
      .out_item   (res_item)
   );

   assign push = advance && res_valid;
   assign pop  = (count_ff != 2'd0) && rsp_tready;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      case ({push, pop})
         2'b10: begin
            count_in = count_ff + 2'd1;
            if (count_ff == 2'd0) begin
               head_in = res_item;
            end else begin
               tail_in = res_item;
            end
         end
         2'b01: begin
            count_in = count_ff - 2'd1;
            head_in  = tail_ff;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               head_in = res_item;
            end else begin
               head_in = tail_ff;
               tail_in = res_item;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tuser  = head_ff.kind;
   assign rsp_tlast  = head_ff.last;
   assign rsp_tdata  = {3'b000, head_ff.status, head_ff.channels, head_ff.image_height,
                        head_ff.image_width, head_ff.repeat_count, head_ff.alpha,
                        head_ff.blue, head_ff.green, head_ff.red};

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != 2'd2))
      else $error("result buffer overflow");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer count out of range");

   a_no_input_loss: assert property (@(posedge clock) disable iff (reset)
      req_take |-> (!in_valid_ff || advance))
      else $error("input item overwritten before use");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import tgarle_pkg::*;

   localparam int STALL_LIMIT = 4000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;   // red, green, blue, alpha, repeat_count, image_width,
                             // image_height, channels, status, zero pad
   logic [1:0]  rsp_tuser;   // [1:0] result_kind
   logic        rsp_tlast;

   tga_rle_image_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // decoder state mirror
   phase_type   tga_phase;
   logic [4:0]  hdr_pos;
   logic [7:0]  id_left;
   logic [7:0]  img_type;
   logic [15:0] img_w;
   logic [15:0] img_h;
   logic [7:0]  bpp;
   logic [31:0] pix_left;
   logic [7:0]  pkt_left;
   logic        pkt_run;
   logic [1:0]  byte_pos;
   logic [23:0] pix_acc;

   rsp_type     pending_records[$];
   rsp_type     exp_rec;
   logic [7:0]  file_buf[$];

   int  error_count = 0;
   int  records_seen = 0;
   int  bytes_sent = 0;
   int  files_sent = 0;
   int  idle_cycles = 0;
   bit  quiet = 1'b0;

   function automatic int pick_gap();
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] rand_byte();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0)
         return 8'h00;
      if (r == 1)
         return 8'hff;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic start_pixel_data();
      byte_pos = '0;
      pix_acc = '0;
      pkt_left = '0;
      pkt_run = 1'b0;
      tga_phase = (img_type == TYPE_RLE) ? PH_PACKET : PH_PIXEL;
   endtask

   // advance the mirror by one file byte and queue the record it produces
   task automatic decode_tga_byte(input logic [7:0] b, input logic eof);
      rsp_type     rec;
      bit          emit;
      logic [31:0] run_len;
      logic [31:0] color;
      logic [2:0]  depth;
      rec = '0;
      emit = 1'b0;
      depth = (bpp == BPP_32) ? 3'd4 : 3'd3;
      case (tga_phase)
         PH_HEADER: begin
            case (hdr_pos)
               HDR_ID_LEN:    id_left = b;
               HDR_TYPE:      img_type = b;
               HDR_WIDTH_LO:  img_w[7:0] = b;
               HDR_WIDTH_HI:  img_w[15:8] = b;
               HDR_HEIGHT_LO: img_h[7:0] = b;
               HDR_HEIGHT_HI: img_h[15:8] = b;
               HDR_BPP:       bpp = b;
               default: ;
            endcase
            if (hdr_pos != HDR_LAST) begin
               hdr_pos = hdr_pos + 5'd1;
            end else begin
               hdr_pos = '0;
               emit = 1'b1;
               if (img_type != TYPE_TRUECOLOR && img_type != TYPE_RLE) begin
                  rec.kind = KIND_ERROR;
                  rec.status = STAT_BAD_TYPE;
                  rec.last = 1'b1;
                  tga_phase = PH_DONE;
               end else if (bpp != BPP_24 && bpp != BPP_32) begin
                  rec.kind = KIND_ERROR;
                  rec.status = STAT_BAD_DEPTH;
                  rec.last = 1'b1;
                  tga_phase = PH_DONE;
               end else begin
                  pix_left = {16'd0, img_w} * {16'd0, img_h};
                  rec.kind = KIND_HEADER;
                  rec.image_width = img_w;
                  rec.image_height = img_h;
                  rec.channels = (bpp == BPP_32) ? 3'd4 : 3'd3;
                  if (pix_left == 0) begin
                     rec.last = 1'b1;
                     tga_phase = PH_DONE;
                  end else if (id_left != 0) begin
                     tga_phase = PH_ID;
                  end else begin
                     start_pixel_data();
                  end
               end
            end
         end
         PH_ID: begin
            id_left = id_left - 8'd1;
            if (id_left == 0)
               start_pixel_data();
         end
         PH_PACKET: begin
            pkt_run = b[7];
            pkt_left = (b & PKT_COUNT_MASK) + 8'd1;
            byte_pos = '0;
            pix_acc = '0;
            tga_phase = PH_PIXEL;
         end
         PH_PIXEL: begin
            if (byte_pos + 1 < depth) begin
               pix_acc = pix_acc | ({16'd0, b} << (8 * byte_pos));
               byte_pos = byte_pos + 2'd1;
            end else begin
               color = {8'd0, pix_acc} | ({24'd0, b} << (8 * byte_pos));
               run_len = (img_type == TYPE_RLE && pkt_run) ? {24'd0, pkt_left} : 32'd1;
               if (run_len > pix_left)
                  run_len = pix_left;
               pix_left = pix_left - run_len;
               rec.kind = KIND_RUN;
               rec.red = color[23:16];
               rec.green = color[15:8];
               rec.blue = color[7:0];
               rec.alpha = (depth == 3'd4) ? color[31:24] : 8'd0;
               rec.repeat_count = run_len[7:0];
               rec.channels = depth;
               emit = 1'b1;
               byte_pos = '0;
               pix_acc = '0;
               if (pix_left == 0) begin
                  rec.last = 1'b1;
                  tga_phase = PH_DONE;
               end else if (img_type == TYPE_RLE) begin
                  if (pkt_run)
                     pkt_left = '0;
                  else
                     pkt_left = pkt_left - 8'd1;
                  if (pkt_left == 0)
                     tga_phase = PH_PACKET;
               end
            end
         end
         default: tga_phase = PH_DONE;
      endcase
      if (eof) begin
         // early end of file overrides whatever this byte produced
         if (tga_phase != PH_DONE) begin
            rec = '0;
            rec.kind = KIND_ERROR;
            rec.status = STAT_TRUNC;
            rec.last = 1'b1;
            emit = 1'b1;
         end
         tga_phase = PH_HEADER;
         hdr_pos = '0;
      end
      if (emit)
         pending_records.push_back(rec);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic eof);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= eof;
      do @(posedge clock); while (!req_tready);
      decode_tga_byte(b, eof);
      bytes_sent++;
   endtask

   task automatic send_file();
      foreach (file_buf[i])
         send_byte(file_buf[i], i == file_buf.size() - 1);
      file_buf.delete();
      files_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_records.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic add_header(input logic [7:0] id_len, input logic [7:0] img_kind,
                             input logic [15:0] w, input logic [15:0] h,
                             input logic [7:0] bits);
      file_buf.push_back(id_len);
      file_buf.push_back(rand_byte());            // color map type
      file_buf.push_back(img_kind);
      repeat (9) file_buf.push_back(rand_byte()); // map spec and origin
      file_buf.push_back(w[7:0]);
      file_buf.push_back(w[15:8]);
      file_buf.push_back(h[7:0]);
      file_buf.push_back(h[15:8]);
      file_buf.push_back(bits);
      file_buf.push_back(rand_byte());            // descriptor
      repeat (id_len) file_buf.push_back(rand_byte());
   endtask

   task automatic add_pixels(input int n, input int depth);
      repeat (n * depth) file_buf.push_back(rand_byte());
   endtask

   task automatic add_image_data(input logic [7:0] img_kind, input int depth, input int npix);
      int         left;
      int         c;
      logic [7:0] cnt_byte;
      if (img_kind != TYPE_RLE) begin
         add_pixels(npix, depth);
      end else begin
         left = npix;
         while (left > 0) begin
            c = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 4);
            cnt_byte = 8'(c - 1);
            if ($urandom_range(0, 1)) begin
               file_buf.push_back(PKT_RUN_MASK | cnt_byte);
               add_pixels(1, depth);
            end else begin
               file_buf.push_back(cnt_byte);
               add_pixels((c > left) ? left : c, depth);
            end
            left -= c;
         end
      end
   endtask

   task automatic truncate_file(input int keep);
      while (file_buf.size() > keep)
         void'(file_buf.pop_back());
   endtask

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("record %0d %s: got %0d, expected %0d",
                                   records_seen, name, got, want));
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         records_seen++;
         if (pending_records.size() == 0) begin
            report_mismatch($sformatf("record %0d arrived with none expected", records_seen));
         end else begin
            exp_rec = pending_records.pop_front();
            check_field("result_kind", rsp_tuser, exp_rec.kind);
            check_field("red", rsp_tdata[7:0], exp_rec.red);
            check_field("green", rsp_tdata[15:8], exp_rec.green);
            check_field("blue", rsp_tdata[23:16], exp_rec.blue);
            check_field("alpha", rsp_tdata[31:24], exp_rec.alpha);
            check_field("repeat_count", rsp_tdata[39:32], exp_rec.repeat_count);
            check_field("image_width", rsp_tdata[55:40], exp_rec.image_width);
            check_field("image_height", rsp_tdata[71:56], exp_rec.image_height);
            check_field("channels", rsp_tdata[74:72], exp_rec.channels);
            check_field("status", rsp_tdata[76:75], exp_rec.status);
            check_field("last", rsp_tlast, exp_rec.last);
         end
      end
   end

   // downstream stalls
   initial begin
      int hold;
      hold = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= 1'b1;
            hold = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d records outstanding",
                  STALL_LIMIT, pending_records.size());
         $display("tga_rle_image_decoder test failed");
         $finish;
      end
   end

   // width and height of the header currently in the file buffer
   function automatic logic [15:0] img_w_of_buf();
      return {file_buf[13], file_buf[12]};
   endfunction

   function automatic logic [15:0] img_h_of_buf();
      return {file_buf[15], file_buf[14]};
   endfunction

   task automatic test_rejected_headers();
      // unsupported type, followed by ignored bytes
      add_header(8'd0, 8'd1, 16'd2, 16'd2, BPP_24);
      add_pixels(1, 3);
      send_file();
      // bad pixel size, end of file on the last header byte
      add_header(8'd0, TYPE_RLE, 16'd2, 16'd2, 8'd16);
      send_file();
      // both wrong: type wins
      add_header(8'd2, 8'd3, 16'd1, 16'd1, 8'd16);
      send_file();
   endtask

   task automatic test_empty_images();
      add_header(8'd0, TYPE_TRUECOLOR, 16'hffff, 16'd0, BPP_32);
      add_pixels(2, 3);  // footer bytes
      send_file();
      add_header(8'd1, TYPE_RLE, 16'd0, 16'hffff, BPP_24);
      truncate_file(18);
      send_file();
   endtask

   task automatic test_raw_images();
      add_header(8'd3, TYPE_TRUECOLOR, 16'd3, 16'd2, BPP_24);
      add_pixels(6, 3);
      send_file();
      add_header(8'd0, TYPE_TRUECOLOR, 16'd2, 16'd2, BPP_32);
      add_pixels(4, 4);
      add_pixels(1, 4);  // trailing bytes
      send_file();
   endtask

   task automatic test_rle_images();
      quiet = 1'b1;
      // 128-pixel run followed by a 16-pixel raw packet
      add_header(8'd0, TYPE_RLE, 16'd16, 16'd9, BPP_24);
      file_buf.push_back(8'hff);
      add_pixels(1, 3);
      file_buf.push_back(8'h0f);
      add_pixels(16, 3);
      send_file();
      quiet = 1'b0;
      // raw packet of 128 in a 3-pixel image
      add_header(8'd0, TYPE_RLE, 16'd3, 16'd1, BPP_24);
      file_buf.push_back(PKT_COUNT_MASK);
      add_pixels(3, 3);
      send_file();
      // run longer than the image is clamped
      add_header(8'd0, TYPE_RLE, 16'd2, 16'd3, BPP_32);
      file_buf.push_back(8'hff);
      add_pixels(1, 4);
      send_file();
      // single-pixel run then single-pixel raw packet
      add_header(8'd2, TYPE_RLE, 16'd1, 16'd2, BPP_32);
      file_buf.push_back(PKT_RUN_MASK);
      add_pixels(1, 4);
      file_buf.push_back(8'h00);
      add_pixels(1, 4);
      send_file();
   endtask

   task automatic test_truncation();
      add_header(8'd0, TYPE_RLE, 16'd4, 16'd4, BPP_24);
      truncate_file(6);  // inside header
      send_file();
      add_header(8'd5, TYPE_TRUECOLOR, 16'd2, 16'd2, BPP_32);
      truncate_file(20);  // inside ID field
      send_file();
      add_header(8'd0, TYPE_RLE, 16'd3, 16'd3, BPP_24);
      file_buf.push_back(8'h02);  // ends on a packet byte
      send_file();
      add_header(8'd0, TYPE_TRUECOLOR, 16'd2, 16'd2, BPP_24);
      add_pixels(1, 3);
      file_buf.push_back(rand_byte());  // ends mid pixel
      send_file();
      // huge image cut after two pixels: truncation replaces the run
      add_header(8'd0, TYPE_TRUECOLOR, 16'hffff, 16'hffff, BPP_32);
      add_pixels(2, 4);
      send_file();
      // valid header ending on its last byte: truncation replaces the header
      add_header(8'd0, TYPE_RLE, 16'd2, 16'd2, BPP_32);
      send_file();
   endtask

   task automatic test_random_files();
      int         stop_at;
      int         r;
      int         depth;
      logic [7:0] img_kind;
      logic [7:0] bits;
      stop_at = bytes_sent + 40;
      while (bytes_sent < stop_at) begin
         if ($urandom_range(0, 4) == 0)
            quiet = ~quiet;
         r = $urandom_range(0, 99);
         if (r < 70) begin
            img_kind = $urandom_range(0, 1) ? TYPE_RLE : TYPE_TRUECOLOR;
            bits = $urandom_range(0, 1) ? BPP_32 : BPP_24;
            depth = (bits == BPP_32) ? 4 : 3;
            add_header(8'($urandom_range(0, 3)), img_kind, 16'($urandom_range(1, 4)),
                       16'($urandom_range(1, 3)), bits);
            add_image_data(img_kind, depth, {16'd0, img_w_of_buf()} * {16'd0, img_h_of_buf()});
            r = $urandom_range(0, 99);
            if (r < 25)
               add_pixels($urandom_range(1, 4), 1);
            else if (r < 40)
               truncate_file($urandom_range(1, file_buf.size() - 1));
         end else if (r < 80) begin
            add_header(8'($urandom_range(0, 3)), rand_byte(), {8'd0, rand_byte()},
                       {8'd0, rand_byte()}, rand_byte());
            add_pixels($urandom_range(0, 3), 1);
         end else if (r < 88) begin
            if ($urandom_range(0, 1))
               add_header(8'($urandom_range(0, 2)), TYPE_RLE, {rand_byte(), rand_byte()},
                          16'd0, BPP_24);
            else
               add_header(8'($urandom_range(0, 2)), TYPE_TRUECOLOR, 16'd0,
                          {rand_byte(), rand_byte()}, BPP_32);
            add_pixels($urandom_range(0, 2), 1);
         end else begin
            add_pixels($urandom_range(1, 30), 1);  // noise
         end
         send_file();
      end
      quiet = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      tga_phase = PH_HEADER;
      hdr_pos = '0;
      id_left = '0;
      img_type = '0;
      img_w = '0;
      img_h = '0;
      bpp = '0;
      pix_left = '0;
      pkt_left = '0;
      pkt_run = 1'b0;
      byte_pos = '0;
      pix_acc = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_rejected_headers();
      drain();
      test_empty_images();
      drain();
      test_raw_images();
      drain();
      test_rle_images();
      drain();
      test_truncation();
      drain();
      test_random_files();
      drain();
      repeat (10) @(posedge clock);

      $display("decoded %0d files (%0d bytes) covering rejects, empty, raw, RLE and cut-off images",
               files_sent, bytes_sent);
      $display("checked %0d result records, %0d mismatches", records_seen, error_count);
      if (error_count == 0)
         $display("tga_rle_image_decoder test passed");
      else
         $display("tga_rle_image_decoder test failed");
      $finish;
   end

endmodule
